// ===== rtl/core/sqm_pkg.sv =====
// Shared types and constants for the streaming quantile marker block.
package sqm_pkg;

  localparam int HW = 32;   // marker height, signed Q16.16
  localparam int PW = 32;   // integer marker position
  localparam int DW = 48;   // desired position, Q32.16
  localparam int IW = 17;   // desired position increment, Q1.16
  localparam int XW = 5;    // entry_index and cell_index width
  localparam int OPW = 2;

  localparam logic [OPW-1:0] OP_OBSERVE = 2'd0;
  localparam logic [OPW-1:0] OP_WRITE   = 2'd1;
  localparam logic [OPW-1:0] OP_READ    = 2'd2;

  localparam logic ARITH_MUL = 1'b0;
  localparam logic ARITH_DIV = 1'b1;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [OPW-1:0]       op;
    logic [XW-1:0]        idx;
    logic signed [HW-1:0] sample;
    logic [PW-1:0]        pos;
    logic [DW-1:0]        desired;
    logic [IW-1:0]        inc;
  } req_t;

  typedef struct packed {
    logic [XW-1:0]        cell_idx;
    logic signed [HW-1:0] height;
    logic [PW-1:0]        pos;
    logic [DW-1:0]        desired;
  } rsp_t;

  typedef struct packed {
    logic signed [HW-1:0] height;
    logic [PW-1:0]        pos;
    logic [DW-1:0]        desired;
    logic [IW-1:0]        inc;
  } entry_t;

  typedef struct packed {
    logic start;
    logic mode;
    logic long_div;
  } arith_cmd_t;

endpackage

// ===== rtl/core/sqm_arith.sv =====
// Shared serial unit: shift-add multiply and restoring divide on magnitudes.
module sqm_arith import sqm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  arith_cmd_t  cmd,
  input  logic [63:0] opa,
  input  logic [32:0] opb,
  output logic        busy,
  output logic        done,
  output logic [65:0] result
);

  localparam logic [6:0] DIV_SHORT = 7'd32;
  localparam logic [6:0] DIV_LONG  = 7'd64;
  localparam logic [6:0] MUL_STEPS = 7'd33;

  logic [32:0] hi;
  logic [63:0] lo;
  logic [32:0] mc;
  logic [6:0]  cnt;
  logic        mode;

  logic [32:0] trial;
  logic        fits;
  logic [33:0] sum;

  always_comb begin
    trial = {hi[31:0], lo[63]};
    fits  = (trial >= mc);
    sum   = {1'b0, hi} + (lo[0] ? {1'b0, mc} : 34'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        mode <= cmd.mode;
        hi   <= '0;
        if (cmd.mode == ARITH_DIV) begin
          lo  <= cmd.long_div ? opa : {opa[31:0], 32'd0};
          cnt <= cmd.long_div ? DIV_LONG : DIV_SHORT;
          mc  <= {1'b0, opb[31:0]};
        end else begin
          lo  <= {31'd0, opb};
          cnt <= MUL_STEPS;
          mc  <= opa[32:0];
        end
      end else if (busy) begin
        if (mode == ARITH_DIV) begin
          hi <= fits ? (trial - mc) : trial;
          lo <= {lo[62:0], fits};
        end else begin
          hi <= sum[33:1];
          lo <= {31'd0, sum[0], lo[32:1]};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (mode == ARITH_DIV) ? {2'd0, lo} : {hi, lo[32:0]};

  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |-> !busy)
    else $error("arith start while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("arith done without a running operation");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> (cnt != 7'd0))
    else $error("arith running with zero step count");

endmodule

// ===== rtl/core/sqm_core.sv =====
// Marker store and sequencer: cell search, position sweep and marker moves.
module sqm_core import sqm_pkg::*; #(
  parameter int MARKER_COUNT = 25,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req_in,
  output logic ready,
  output logic rsp_valid,
  output rsp_t rsp,
  input  logic rsp_take
);

  localparam int AW = $clog2(MARKER_COUNT);
  localparam int OFF_W = ((PW + FRAC_BITS) > DW ? PW + FRAC_BITS : DW) + 1;
  localparam logic [AW-1:0] LAST = AW'(MARKER_COUNT - 1);
  localparam logic [AW-1:0] PENULT = AW'(MARKER_COUNT - 2);
  localparam logic signed [64:0] SMAX65 = {1'b0, SMAX};
  localparam logic signed [64:0] NMAX65 = -SMAX65;
  localparam logic signed [OFF_W-1:0] ONE = OFF_W'(1) << FRAC_BITS;

  localparam logic [4:0] ST_IDLE       = 5'd0;
  localparam logic [4:0] ST_RESP       = 5'd1;
  localparam logic [4:0] ST_RD_ISSUE   = 5'd2;
  localparam logic [4:0] ST_RD_USE     = 5'd3;
  localparam logic [4:0] ST_SRCH_ISSUE = 5'd4;
  localparam logic [4:0] ST_SRCH_USE   = 5'd5;
  localparam logic [4:0] ST_SWP_ISSUE  = 5'd6;
  localparam logic [4:0] ST_SWP_USE    = 5'd7;
  localparam logic [4:0] ST_MV_RD_M    = 5'd8;
  localparam logic [4:0] ST_MV_RD_C    = 5'd9;
  localparam logic [4:0] ST_MV_RD_P    = 5'd10;
  localparam logic [4:0] ST_MV_LATCH   = 5'd11;
  localparam logic [4:0] ST_MV_EVAL    = 5'd12;
  localparam logic [4:0] ST_QP         = 5'd13;
  localparam logic [4:0] ST_QP_W       = 5'd14;
  localparam logic [4:0] ST_QM         = 5'd15;
  localparam logic [4:0] ST_QM_W       = 5'd16;
  localparam logic [4:0] ST_M1         = 5'd17;
  localparam logic [4:0] ST_M1_W       = 5'd18;
  localparam logic [4:0] ST_M2         = 5'd19;
  localparam logic [4:0] ST_M2_W       = 5'd20;
  localparam logic [4:0] ST_NUM        = 5'd21;
  localparam logic [4:0] ST_DV         = 5'd22;
  localparam logic [4:0] ST_DV_W       = 5'd23;
  localparam logic [4:0] ST_QT         = 5'd24;
  localparam logic [4:0] ST_FIN        = 5'd25;
  localparam logic [4:0] ST_NEXT       = 5'd26;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    mag34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
    if (s > SMAX65) sat65 = SMAX;
    else if (s < NMAX65) sat65 = -SMAX;
    else sat65 = s[63:0];
  endfunction

  entry_t mem [MARKER_COUNT];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  entry_t mem_wd;

  logic [4:0] state;
  req_t req;
  logic [AW-1:0] cnt;
  logic [AW-1:0] hit_cell;
  logic prev_le;

  entry_t ec;
  logic signed [HW-1:0] hm, hp;
  logic [PW-1:0] pm, pp;
  logic signed [32:0] dp, dm, dpm;
  logic up;
  logic signed [32:0] qp, qm;
  logic signed [63:0] p1, p2, num, quo, qt;
  logic op_neg, op_zero;

  arith_cmd_t arith_cmd;
  logic [63:0] arith_a;
  logic [32:0] arith_b;
  logic arith_busy, arith_done;
  logic [65:0] arith_res;

  logic signed [63:0] div_s;
  logic signed [32:0] div_d;
  logic signed [33:0] mul_x;
  logic signed [32:0] mul_y;
  logic neg_c;

  logic signed [32:0] diff_p, diff_m;
  logic signed [32:0] dp_c, dm_c;
  logic signed [OFF_W-1:0] off_c;
  logic up_c, dn_c;
  logic signed [63:0] div_val, mul_val, m63;
  logic signed [64:0] num_sum, qt_sum;
  logic in_range, qt_ok;
  logic signed [HW-1:0] x, h_rd;
  logic found;

  sqm_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (arith_cmd),
    .opa    (arith_a),
    .opb    (arith_b),
    .busy   (arith_busy),
    .done   (arith_done),
    .result (arith_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    x      = $signed(req.sample);
    h_rd   = $signed(rd_data.height);
    found  = prev_le && (x < h_rd);
    diff_p = $signed({hp[HW-1], hp}) - $signed({ec.height[HW-1], ec.height});
    diff_m = $signed({hm[HW-1], hm}) - $signed({ec.height[HW-1], ec.height});
    dp_c   = $signed({1'b0, pp}) - $signed({1'b0, ec.pos});
    dm_c   = $signed({1'b0, pm}) - $signed({1'b0, ec.pos});
    off_c  = $signed(OFF_W'(ec.desired)) - $signed(OFF_W'(ec.pos) << FRAC_BITS);
    up_c   = (off_c >= ONE) && (dp_c > 33'sd1);
    dn_c   = (off_c <= -ONE) && (dm_c < -33'sd1);
    in_range = (32'(req_in.idx) < MARKER_COUNT);

    div_val = op_zero ? 64'sd0 : (op_neg ? -$signed(arith_res[63:0]) : $signed(arith_res[63:0]));
    m63     = (|arith_res[65:63]) ? SMAX : $signed({1'b0, arith_res[62:0]});
    mul_val = op_neg ? -m63 : m63;

    num_sum = $signed({p1[63], p1}) + (up ? $signed({p2[63], p2}) : -$signed({p2[63], p2}));
    qt_sum  = $signed(65'(ec.height)) + (up ? $signed({quo[63], quo}) : -$signed({quo[63], quo}));
    qt_ok   = ($signed(64'(hm)) < qt) && (qt < $signed(64'(hp)));
  end

  // Arithmetic unit command and memory access per state.
  always_comb begin
    arith_cmd = '0;
    div_s     = '0;
    div_d     = '0;
    mul_x     = '0;
    mul_y     = '0;
    mem_we    = 1'b0;
    mem_wa    = cnt;
    mem_wd    = rd_data;
    rd_addr   = cnt;
    case (state)
      ST_IDLE: begin
        if (req_valid && req_in.op == OP_WRITE && in_range) begin
          mem_we = 1'b1;
          mem_wa = AW'(req_in.idx);
          mem_wd = '{height: req_in.sample, pos: req_in.pos,
                     desired: req_in.desired, inc: req_in.inc};
        end
      end
      ST_RD_ISSUE: rd_addr = AW'(req.idx);
      ST_SRCH_USE: begin
        // widen the end markers
        if ((cnt == '0 && x < h_rd) || (cnt == LAST && !found && x > h_rd)) begin
          mem_we = 1'b1;
          mem_wd.height = x;
        end
      end
      ST_SWP_USE: begin
        mem_we = 1'b1;
        mem_wd.desired = rd_data.desired + DW'(rd_data.inc);
        if (cnt > hit_cell) mem_wd.pos = rd_data.pos + PW'(1);
      end
      ST_MV_RD_M: rd_addr = cnt - AW'(1);
      ST_MV_RD_P: rd_addr = cnt + AW'(1);
      ST_QP: begin
        arith_cmd = '{start: 1'b1, mode: ARITH_DIV, long_div: 1'b0};
        div_s = 64'(diff_p);
        div_d = dp;
      end
      ST_QM: begin
        arith_cmd = '{start: 1'b1, mode: ARITH_DIV, long_div: 1'b0};
        div_s = 64'(diff_m);
        div_d = dm;
      end
      ST_M1: begin
        arith_cmd = '{start: 1'b1, mode: ARITH_MUL, long_div: 1'b0};
        mul_x = up ? (34'sd1 - $signed({dm[32], dm})) : (34'sd1 + $signed({dp[32], dp}));
        mul_y = up ? qp : qm;
      end
      ST_M2: begin
        arith_cmd = '{start: 1'b1, mode: ARITH_MUL, long_div: 1'b0};
        mul_x = up ? ($signed({dp[32], dp}) - 34'sd1) : ($signed({dm[32], dm}) + 34'sd1);
        mul_y = up ? qm : qp;
      end
      ST_DV: begin
        arith_cmd = '{start: 1'b1, mode: ARITH_DIV, long_div: 1'b1};
        div_s = num;
        div_d = dpm;
      end
      ST_FIN: begin
        mem_we = 1'b1;
        mem_wd = ec;
        if (qt_ok) mem_wd.height = qt[HW-1:0];
        else if (up) mem_wd.height = ec.height + qp[HW-1:0];
        else mem_wd.height = ec.height - qm[HW-1:0];
        mem_wd.pos = up ? (ec.pos + PW'(1)) : (ec.pos - PW'(1));
      end
      default: ;
    endcase
    if (arith_cmd.mode == ARITH_DIV) begin
      arith_a = mag64(div_s);
      arith_b = mag33(div_d);
      neg_c   = div_s[63] ^ div_d[32];
    end else begin
      arith_a = 64'(mag34(mul_x));
      arith_b = mag33(mul_y);
      neg_c   = mul_x[33] ^ mul_y[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      if (arith_cmd.start) begin
        op_neg  <= neg_c;
        op_zero <= (div_d == 33'sd0);
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req <= req_in;
            rsp <= '0;
            cnt <= '0;
            case (req_in.op)
              OP_OBSERVE: state <= ST_SRCH_ISSUE;
              OP_READ:    state <= in_range ? ST_RD_ISSUE : ST_RESP;
              default:    state <= ST_RESP;
            endcase
          end
        end
        ST_RD_ISSUE: state <= ST_RD_USE;
        ST_RD_USE: begin
          rsp.height  <= rd_data.height;
          rsp.pos     <= rd_data.pos;
          rsp.desired <= rd_data.desired;
          state       <= ST_RESP;
        end
        ST_SRCH_ISSUE: state <= ST_SRCH_USE;
        ST_SRCH_USE: begin
          if (cnt == '0 && x < h_rd) begin
            hit_cell <= '0;
            state    <= ST_SWP_ISSUE;
          end else if (cnt != '0 && found) begin
            hit_cell <= cnt - AW'(1);
            cnt      <= '0;
            state    <= ST_SWP_ISSUE;
          end else if (cnt == LAST) begin
            hit_cell <= PENULT;
            cnt      <= '0;
            state    <= ST_SWP_ISSUE;
          end else begin
            prev_le <= (h_rd <= x);
            cnt     <= cnt + AW'(1);
            state   <= ST_SRCH_ISSUE;
          end
        end
        ST_SWP_ISSUE: begin
          rsp.cell_idx <= XW'(hit_cell);
          state        <= ST_SWP_USE;
        end
        ST_SWP_USE: begin
          if (cnt == LAST) begin
            cnt   <= AW'(1);
            state <= ST_MV_RD_M;
          end else begin
            cnt   <= cnt + AW'(1);
            state <= ST_SWP_ISSUE;
          end
        end
        ST_MV_RD_M: state <= ST_MV_RD_C;
        ST_MV_RD_C: begin
          hm    <= rd_data.height;
          pm    <= rd_data.pos;
          state <= ST_MV_RD_P;
        end
        ST_MV_RD_P: begin
          ec    <= rd_data;
          state <= ST_MV_LATCH;
        end
        ST_MV_LATCH: begin
          hp    <= rd_data.height;
          pp    <= rd_data.pos;
          state <= ST_MV_EVAL;
        end
        ST_MV_EVAL: begin
          dp    <= dp_c;
          dm    <= dm_c;
          dpm   <= $signed({1'b0, pp}) - $signed({1'b0, pm});
          up    <= up_c;
          state <= (up_c || dn_c) ? ST_QP : ST_NEXT;
        end
        ST_QP: state <= ST_QP_W;
        ST_QP_W: begin
          if (arith_done) begin
            qp    <= div_val[32:0];
            state <= ST_QM;
          end
        end
        ST_QM: state <= ST_QM_W;
        ST_QM_W: begin
          if (arith_done) begin
            qm    <= div_val[32:0];
            state <= ST_M1;
          end
        end
        ST_M1: state <= ST_M1_W;
        ST_M1_W: begin
          if (arith_done) begin
            p1    <= mul_val;
            state <= ST_M2;
          end
        end
        ST_M2: state <= ST_M2_W;
        ST_M2_W: begin
          if (arith_done) begin
            p2    <= mul_val;
            state <= ST_NUM;
          end
        end
        ST_NUM: begin
          num   <= sat65(num_sum);
          state <= ST_DV;
        end
        ST_DV: state <= ST_DV_W;
        ST_DV_W: begin
          if (arith_done) begin
            quo   <= div_val;
            state <= ST_QT;
          end
        end
        ST_QT: begin
          qt    <= sat65(qt_sum);
          state <= ST_FIN;
        end
        ST_FIN: state <= ST_NEXT;
        ST_NEXT: begin
          if (cnt == PENULT) begin
            state <= ST_RESP;
          end else begin
            cnt   <= cnt + AW'(1);
            state <= ST_MV_RD_M;
          end
        end
        ST_RESP: if (rsp_take) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign ready     = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);

  a_ready_unit_idle: assert property (@(posedge clk) disable iff (rst)
    ready |-> !arith_busy)
    else $error("idle while the arithmetic unit runs");
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_wa <= LAST))
    else $error("marker write beyond the last entry");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    arith_done |-> (state == ST_QP_W || state == ST_QM_W || state == ST_M1_W ||
                    state == ST_M2_W || state == ST_DV_W))
    else $error("arithmetic result with no state waiting for it");
  a_take_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_take) |=> ready)
    else $error("response taken but not back to idle");

endmodule

// ===== rtl/core/streaming_quantile_markers.sv =====
// Extended P-square streaming quantile estimator, top level with output register.
// One transaction is taken at a time: in_stall stays high until the result of the
// previous transaction has moved into the output register. A write stores the entry
// as it is taken; a read fetches the entry from the marker memory. An observe runs a
// cell search over the markers (ending early when the cell is found), a desired-position
// sweep over all markers, then a check of each inner marker and a move for those that
// must move; the move time is set by the single serial multiply/divide unit (two
// 32-step divides, two 33-step multiplies and one 64-step divide) and by the one read
// port of the marker memory.
// Software loads all markers with writes before the first observe.
module streaming_quantile_markers import sqm_pkg::*; #(
  parameter int MARKER_COUNT = 25,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPW-1:0]       op,
  input  logic [XW-1:0]        entry_index,
  input  logic signed [HW-1:0] sample_value,
  input  logic [PW-1:0]        entry_position,
  input  logic [DW-1:0]        entry_desired,
  input  logic [IW-1:0]        entry_increment,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [XW-1:0]        cell_index,
  output logic signed [HW-1:0] read_height,
  output logic [PW-1:0]        read_position,
  output logic [DW-1:0]        read_desired
);

  req_t req;
  rsp_t core_rsp;
  rsp_t out_rsp;
  logic core_ready;
  logic core_rsp_valid;
  logic rsp_take;

  assign req = '{op: op, idx: entry_index, sample: sample_value, pos: entry_position,
                 desired: entry_desired, inc: entry_increment};

  sqm_core #(
    .MARKER_COUNT (MARKER_COUNT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid && core_ready),
    .req_in    (req),
    .ready     (core_ready),
    .rsp_valid (core_rsp_valid),
    .rsp       (core_rsp),
    .rsp_take  (rsp_take)
  );

  assign in_stall = !core_ready;
  // load the output register when it is empty or draining this cycle
  assign rsp_take = core_rsp_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) out_rsp <= core_rsp;
  end

  assign cell_index    = out_rsp.cell_idx;
  assign read_height   = out_rsp.height;
  assign read_position = out_rsp.pos;
  assign read_desired  = out_rsp.desired;

endmodule
